// ===== rtl/vra_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vra_pkg: shared types, constants and float helpers
// Queue word type, request codes, binary16 widening and the binary32 rounding
// and addition functions used by both the term pipeline and the accumulator.
// ----------------------------------------------------------------------------
package vra_pkg;

	localparam int QUEUE_DEPTH = 8;

	localparam logic [1:0] REQ_SUM = 2'd0;
	localparam logic [1:0] REQ_DOT = 2'd1;
	localparam logic [1:0] REQ_SQD = 2'd2;
	localparam logic [1:0] REQ_ALT = 2'd3;	// treated as a plain sum

	localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

	// One queued term with its vector marks
	typedef struct packed {
		logic [31:0] term;
		logic        last;
		logic        empty;
	} qent_t;

	// Exact widening of a binary16 pattern to binary32
	function automatic logic [31:0] f16_to_f32(input logic [15:0] h);
		logic [4:0]  ex;
		logic [9:0]  fr;
		logic [3:0]  p;
		logic [9:0]  nf;
		logic [31:0] r;
		ex = h[14:10];
		fr = h[9:0];
		p  = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (fr[i]) p = 4'(i);
		end
		nf = fr << (4'd10 - p);
		if (ex == 5'h1F) begin
			r = (fr != 10'd0) ? CANON_NAN : {h[15], 8'hFF, 23'd0};
		end else if (ex == 5'd0) begin
			if (fr == 10'd0) r = {h[15], 31'd0};
			else r = {h[15], {4'd0, p} + 8'd103, nf, 13'd0};
		end else begin
			r = {h[15], {3'd0, ex} + 8'd112, fr, 13'd0};
		end
		return r;
	endfunction

	// Normalize and round to nearest-even; value = m * 2^(e-47).
	// half selects binary16 precision/range, result widened to binary32.
	function automatic logic [31:0] fp_round(input logic sgn, input logic signed [9:0] e,
			input logic [47:0] m, input logic half);
		logic [5:0]        lz;
		logic signed [9:0] emin;
		logic signed [9:0] en;
		logic signed [9:0] elz;
		logic [47:0]       x;
		logic [95:0]       ext;
		logic [9:0]        sh;
		logic              st;
		logic              inc;
		logic [24:0]       q32;
		logic [11:0]       q16;
		logic [15:0]       h;
		logic [31:0]       r;
		lz = 6'd0;
		for (int i = 0; i < 48; i++) begin
			if (m[i]) lz = 6'(47 - i);
		end
		emin = half ? -10'sd14 : -10'sd126;
		elz  = e - signed'({4'd0, lz});
		st   = 1'b0;
		en   = emin;
		sh   = 10'd0;
		x    = 48'd0;
		ext  = 96'd0;
		// normal, partly normalized subnormal, or right shift into subnormal range
		if (elz >= emin) begin
			x  = m << lz;
			en = elz;
		end else if (e >= emin) begin
			sh = 10'(e - emin);
			x  = m << sh;
		end else begin
			sh = 10'(emin - e);
			if (sh > 10'd95) begin
				st = |m;
			end else begin
				ext = {m, 48'd0} >> sh;
				x   = ext[95:48];
				st  = |ext[47:0];
			end
		end
		if (!half) begin
			q32 = {1'b0, x[47:24]};
			inc = x[23] & (st | (|x[22:0]) | x[24]);
			q32 = q32 + 25'(inc);
			if (q32[24]) begin
				q32 = q32 >> 1;
				en  = en + 10'sd1;
			end
			if (!q32[23]) r = {sgn, 8'd0, q32[22:0]};
			else if (en > 10'sd127) r = {sgn, 8'hFF, 23'd0};
			else r = {sgn, 8'(en + 10'sd127), q32[22:0]};
		end else begin
			q16 = {1'b0, x[47:37]};
			inc = x[36] & (st | (|x[35:0]) | x[37]);
			q16 = q16 + 12'(inc);
			if (q16[11]) begin
				q16 = q16 >> 1;
				en  = en + 10'sd1;
			end
			if (!q16[10]) h = {sgn, 5'd0, q16[9:0]};
			else if (en > 10'sd15) h = {sgn, 5'h1F, 10'd0};
			else h = {sgn, 5'(en + 10'sd15), q16[9:0]};
			r = f16_to_f32(h);
		end
		return r;
	endfunction

	// a + b, rounded to binary32 or binary16 precision
	function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b,
			input logic half);
		logic [31:0]       big;
		logic [31:0]       sml;
		logic              nan_a;
		logic              nan_b;
		logic              inf_a;
		logic              inf_b;
		logic [7:0]        eb;
		logic [7:0]        es;
		logic [7:0]        d;
		logic [23:0]       mb;
		logic [23:0]       ms;
		logic [53:0]       full;
		logic [26:0]       xs;
		logic [27:0]       sum;
		logic              sub;
		logic signed [9:0] e;
		logic [31:0]       r;
		nan_a = (&a[30:23]) & (|a[22:0]);
		nan_b = (&b[30:23]) & (|b[22:0]);
		inf_a = (&a[30:23]) & ~(|a[22:0]);
		inf_b = (&b[30:23]) & ~(|b[22:0]);
		if (b[30:0] > a[30:0]) begin
			big = b;
			sml = a;
		end else begin
			big = a;
			sml = b;
		end
		eb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
		mb = {|big[30:23], big[22:0]};
		ms = {|sml[30:23], sml[22:0]};
		d  = eb - es;
		// align the smaller operand, shifted-out bits jam into the lsb
		full = 54'd0;
		if (d > 8'd26) begin
			xs = {26'd0, |ms};
		end else begin
			full  = {ms, 3'b000, 27'd0} >> d;
			xs    = full[53:27];
			xs[0] = xs[0] | (|full[26:0]);
		end
		sub = a[31] ^ b[31];
		sum = sub ? ({1'b0, mb, 3'b000} - {1'b0, xs}) : ({1'b0, mb, 3'b000} + {1'b0, xs});
		e   = signed'({2'd0, eb}) - 10'sd126;
		if (nan_a || nan_b) r = CANON_NAN;
		else if (inf_a && inf_b && sub) r = CANON_NAN;
		else if (inf_a) r = a;
		else if (inf_b) r = b;
		else if (sum == 28'd0) r = {a[31] & b[31], 31'd0};
		else r = fp_round(big[31], e, {sum, 20'd0}, half);
		return r;
	endfunction

endpackage

// ===== rtl/vra_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vra_queue: term queue between front and back
// Small register FIFO; the front reserves room through the level output.
// ----------------------------------------------------------------------------
module vra_queue #(
	parameter int DEPTH = vra_pkg::QUEUE_DEPTH,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int LW = $clog2(DEPTH + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  vra_pkg::qent_t  push_data,
	input  logic            pop,
	output vra_pkg::qent_t  pop_data,
	output logic            nonempty,
	output logic [LW-1:0]   level
);

	vra_pkg::qent_t mem [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [LW-1:0]  level_q;

	assign pop_data = mem[rd_ptr_q];
	assign nonempty = (level_q != LW'(0));
	assign level    = level_q;

	// storage
	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= push_data;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (pop) rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			if (push && !pop) level_q <= level_q + LW'(1);
			else if (pop && !push) level_q <= level_q - LW'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> level_q != LW'(DEPTH))
		else $error("term queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> level_q != LW'(0))
		else $error("term queue read while empty");

endmodule

// ===== rtl/vra_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vra_front: input acceptance and term pipeline
// Widens operands, forms lhs, lhs*rhs or (lhs-rhs)^2 in four stages and
// pushes the term (rounded unless a plain sum) into the queue. Accepts only with queue room.
// ----------------------------------------------------------------------------
module vra_front #(
	parameter int DEPTH = vra_pkg::QUEUE_DEPTH,
	localparam int LW = $clog2(DEPTH + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [63:0]     s_tdata,	// lhs_value[31:0], rhs_value[63:32]
	input  logic [3:0]      s_tuser,	// req_type[1:0], half_format[2], empty_vector[3]
	input  logic            s_tlast,	// last_element
	input  logic [LW-1:0]   level,
	output logic            push,
	output vra_pkg::qent_t  push_data
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic [31:0] a_s1, b_s1;
	logic [1:0]  kind_s1, kind_s2, kind_s3;
	logic        half_s1, half_s2, half_s3;
	logic        last_s1, last_s2, last_s3;
	logic        empty_s1, empty_s2, empty_s3;
	logic [31:0] x_s2, y_s2, x_s3;
	logic [47:0] prod_s3;
	logic signed [9:0] e_s3;
	logic        sgn_s3, nan_s3, inf_s3, zero_s3;
	vra_pkg::qent_t ent_s4;

	logic [2:0]    inflight;
	logic [LW+2:0] used;
	logic          accept;
	logic [31:0]   a_in, b_in, diff;
	logic [1:0]    kind_in;
	logic [7:0]    ex, ey;
	logic signed [9:0] ebx, eby;
	logic          nan_x, nan_y, inf_x, inf_y, zero_x, zero_y;
	logic [31:0]   rounded;

	// credit check: items in flight plus queued must fit the queue
	assign inflight = 3'(v_s1) + 3'(v_s2) + 3'(v_s3) + 3'(v_s4);
	assign used     = (LW+3)'(level) + (LW+3)'(inflight);
	assign s_tready = used < (LW+3)'(DEPTH);
	assign accept   = s_tvalid & s_tready;

	// operand widening and request decode
	always_comb begin
		a_in    = s_tuser[2] ? vra_pkg::f16_to_f32(s_tdata[15:0]) : s_tdata[31:0];
		b_in    = s_tuser[2] ? vra_pkg::f16_to_f32(s_tdata[47:32]) : s_tdata[63:32];
		kind_in = (s_tuser[1:0] == vra_pkg::REQ_ALT) ? vra_pkg::REQ_SUM : s_tuser[1:0];
	end

	// difference for squared distance
	assign diff = vra_pkg::fp_add(a_s1, {~b_s1[31], b_s1[30:0]}, half_s1);

	// significand product and its class
	always_comb begin
		ex     = x_s2[30:23];
		ey     = y_s2[30:23];
		ebx    = (ex == 8'd0) ? -10'sd126 : signed'({2'd0, ex}) - 10'sd127;
		eby    = (ey == 8'd0) ? -10'sd126 : signed'({2'd0, ey}) - 10'sd127;
		nan_x  = (&ex) & (|x_s2[22:0]);
		nan_y  = (&ey) & (|y_s2[22:0]);
		inf_x  = (&ex) & ~(|x_s2[22:0]);
		inf_y  = (&ey) & ~(|y_s2[22:0]);
		zero_x = (x_s2[30:0] == 31'd0);
		zero_y = (y_s2[30:0] == 31'd0);
	end

	// product rounding and term select
	always_comb begin
		if (nan_s3) rounded = vra_pkg::CANON_NAN;
		else if (inf_s3) rounded = {sgn_s3, 8'hFF, 23'd0};
		else if (zero_s3) rounded = {sgn_s3, 31'd0};
		else rounded = vra_pkg::fp_round(sgn_s3, e_s3, prod_s3, half_s3);
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		a_s1     <= a_in;
		b_s1     <= b_in;
		kind_s1  <= kind_in;
		half_s1  <= s_tuser[2];
		last_s1  <= s_tlast;
		empty_s1 <= s_tuser[3];

		x_s2     <= (kind_s1 == vra_pkg::REQ_SQD) ? diff : a_s1;
		y_s2     <= (kind_s1 == vra_pkg::REQ_SQD) ? diff : b_s1;
		kind_s2  <= kind_s1;
		half_s2  <= half_s1;
		last_s2  <= last_s1;
		empty_s2 <= empty_s1;

		prod_s3  <= {|ex, x_s2[22:0]} * {|ey, y_s2[22:0]};
		e_s3     <= ebx + eby + 10'sd1;
		sgn_s3   <= x_s2[31] ^ y_s2[31];
		nan_s3   <= nan_x | nan_y | (inf_x & zero_y) | (zero_x & inf_y);
		inf_s3   <= inf_x | inf_y;
		zero_s3  <= zero_x | zero_y;
		x_s3     <= x_s2;
		kind_s3  <= kind_s2;
		half_s3  <= half_s2;
		last_s3  <= last_s2;
		empty_s3 <= empty_s2;

		ent_s4.term  <= (kind_s3 == vra_pkg::REQ_SUM) ? x_s3 : rounded;
		ent_s4.last  <= last_s3;
		ent_s4.empty <= empty_s3;
	end

	assign push      = v_s4;
	assign push_data = ent_s4;

endmodule

// ===== rtl/vra_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vra_back: accumulator and result register
// Adds each queued term to the binary32 sum, emits on the last element or an
// empty vector, and clears to +0 after each emitted word.
// ----------------------------------------------------------------------------
module vra_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  vra_pkg::qent_t  q_data,
	output logic            pop,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [31:0]     m_tdata	// sum_value
);

	logic [31:0] acc_q;
	logic [31:0] out_q;
	logic        out_valid_q;
	logic [31:0] sum;
	logic [31:0] sum_canon;

	assign pop = q_valid & (~out_valid_q | m_tready);
	assign sum = vra_pkg::fp_add(acc_q, q_data.term, 1'b0);
	assign sum_canon = ((&sum[30:23]) && (|sum[22:0])) ? vra_pkg::CANON_NAN : sum;

	// accumulate and emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				acc_q <= (q_data.empty || q_data.last) ? 32'd0 : sum;
			end
			if (pop && (q_data.empty || q_data.last)) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (pop && (q_data.empty || q_data.last)) begin
			out_q <= q_data.empty ? 32'd0 : sum_canon;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	a_empty_clears: assert property (@(posedge clk) disable iff (!arst_n)
		pop && q_data.empty |=> acc_q == 32'd0 && m_tvalid && m_tdata == 32'd0)
		else $error("empty vector did not emit +0 and clear");

	a_nan_canonical: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (&m_tdata[30:23]) |-> m_tdata[22:0] == 23'd0 ||
			m_tdata == vra_pkg::CANON_NAN)
		else $error("non-canonical NaN on result");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		pop && q_data.last |=> acc_q == 32'd0 && m_tvalid)
		else $error("last element did not emit and clear");

endmodule

// ===== rtl/vector_reduce_accumulator_top.sv =====
`timescale 1ns / 1ps
// A word from s_* passes the term pipeline, queue and result register to m_*.
// Throughput: one word per cycle while not stalled; the loop is the binary32
// accumulator add in the back part, the term pipeline itself has no feedback.
// The front accepts while the term queue (QUEUE_DEPTH words) has room for all
// items in flight, so a stalled output does not block input until it fills.
// Reset: asynchronous, clears all valids, queue pointers and the sum to +0.
// ----------------------------------------------------------------------------
// vector_reduce_accumulator_top: floating-point sum / dot / distance reducer
// Front term pipeline, term queue and back accumulator with result register.
// ----------------------------------------------------------------------------
module vector_reduce_accumulator_top #(
	parameter int QUEUE_DEPTH = vra_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,	// lhs_value[31:0], rhs_value[63:32]
	input  logic [3:0]  s_tuser,	// req_type[1:0], half_format[2], empty_vector[3]
	input  logic        s_tlast,	// last_element
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata	// sum_value[31:0]
);

	localparam int LW = $clog2(QUEUE_DEPTH + 1);

	logic           push;
	logic           pop;
	logic           nonempty;
	logic [LW-1:0]  level;
	vra_pkg::qent_t push_data;
	vra_pkg::qent_t pop_data;

	// term pipeline
	vra_front #(.DEPTH(QUEUE_DEPTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.level     (level),
		.push      (push),
		.push_data (push_data)
	);

	// term queue
	vra_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.nonempty  (nonempty),
		.level     (level)
	);

	// accumulator
	vra_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (nonempty),
		.q_data   (pop_data),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== tb/sv/vector_reduce_accumulator_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_reduce_accumulator_top_test: self-checking bench for the reducer
// Streams vectors of sum, dot and distance elements in binary32 and binary16
// form, predicts each emitted sum bit for bit, and checks it in arrival order
// under random idling on both stream sides.
// ----------------------------------------------------------------------------
module vector_reduce_accumulator_top_test;

	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct {
		logic [1:0]  req;
		logic        half;
		logic [31:0] lhs;
		logic [31:0] rhs;
		logic        last;
		logic        empty;
	} vec_elem_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = 64'd0;	// lhs_value[31:0], rhs_value[63:32]
	logic [3:0]  s_tuser = 4'd0;	// req_type[1:0], half_format[2], empty_vector[3]
	logic        s_tlast = 1'b0;	// last_element
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;	// sum_value[31:0]

	vec_elem_t   pending_elems[$];
	logic [31:0] expected_sums[$];
	vec_elem_t   driven_elem;
	logic [31:0] running_sum = 32'd0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          idle_cycles = 0;
	bit          failed = 1'b0;

	vector_reduce_accumulator_top DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// ---------------- float helpers ----------------

	// Round a double to binary32 or binary16, nearest-even, subnormals kept
	function automatic logic [31:0] round_real(input real d, input bit half);
		logic [63:0] b;
		logic [63:0] m;
		logic [63:0] q;
		logic [63:0] rem;
		logic [63:0] hw;
		logic [31:0] sgn;
		logic [31:0] res;
		logic [31:0] infv;
		int          ex;
		int          sh;
		int          frac;
		int          emin;
		int          emax;
		b    = $realtobits(d);
		frac = half ? 10 : 23;
		emin = half ? -14 : -126;
		emax = half ? 15 : 127;
		sgn  = half ? {16'd0, b[63], 15'd0} : {b[63], 31'd0};
		infv = half ? 32'h0000_7C00 : 32'h7F80_0000;
		if (b[62:52] == 11'h7FF)
			return (b[51:0] != 52'd0) ? (half ? 32'h0000_7E00 : vra_pkg::CANON_NAN)
				: (sgn | infv);
		if (b[62:52] == 11'd0)
			return sgn;
		ex = int'(b[62:52]) - 1023;
		if (ex > emax)
			return sgn | infv;
		m  = {11'd0, 1'b1, b[51:0]};
		sh = (ex >= emin) ? 52 - frac : 52 - frac + (emin - ex);
		if (sh >= 62)
			return sgn;
		q   = m >> sh;
		rem = m & ((64'd1 << sh) - 64'd1);
		hw  = 64'd1 << (sh - 1);
		if (rem > hw || (rem == hw && q[0]))
			q = q + 64'd1;
		res = q[31:0];
		if (ex >= emin)
			res = res + (32'(ex - emin) << frac);
		if (res >= infv)
			res = infv;
		return sgn | res;
	endfunction

	function automatic real single_to_real(input logic [31:0] x);
		real r;
		if (x[30:23] == 8'hFF)
			return $bitstoreal({x[31], 11'h7FF, x[22:0], 29'd0});
		if (x[30:23] == 8'd0) begin
			r = real'(x[22:0]) * $bitstoreal(64'h36A0_0000_0000_0000);	// 2^-149
			return x[31] ? -r : r;
		end
		return $bitstoreal({x[31], 11'(x[30:23]) + 11'd896, x[22:0], 29'd0});
	endfunction

	function automatic real half_to_real(input logic [15:0] h);
		real r;
		if (h[14:10] == 5'h1F)
			return $bitstoreal({h[15], 11'h7FF, h[9:0], 42'd0});
		if (h[14:10] == 5'd0) begin
			r = real'(h[9:0]) * $bitstoreal(64'h3E70_0000_0000_0000);	// 2^-24
			return h[15] ? -r : r;
		end
		return $bitstoreal({h[15], 11'(h[14:10]) + 11'd1008, h[9:0], 42'd0});
	endfunction

	// Per-element term as a binary32 pattern
	function automatic logic [31:0] element_term(input vec_elem_t e);
		real         a;
		real         b;
		real         dd;
		logic [31:0] h;
		if (e.half) begin
			a = half_to_real(e.lhs[15:0]);
			b = half_to_real(e.rhs[15:0]);
			if (e.req == vra_pkg::REQ_DOT) begin
				h = round_real(a * b, 1'b1);
			end else if (e.req == vra_pkg::REQ_SQD) begin
				h  = round_real(a - b, 1'b1);
				dd = half_to_real(h[15:0]);
				h  = round_real(dd * dd, 1'b1);
			end else begin
				h = {16'd0, e.lhs[15:0]};
			end
			return round_real(half_to_real(h[15:0]), 1'b0);
		end
		a = single_to_real(e.lhs);
		b = single_to_real(e.rhs);
		if (e.req == vra_pkg::REQ_DOT)
			return round_real(a * b, 1'b0);
		if (e.req == vra_pkg::REQ_SQD) begin
			dd = single_to_real(round_real(a - b, 1'b0));
			return round_real(dd * dd, 1'b0);
		end
		return e.lhs;
	endfunction

	// Fold one accepted element into the running sum, queue the emitted sum
	task automatic fold_element(input vec_elem_t e);
		logic [31:0] s;
		if (e.empty) begin
			running_sum = 32'd0;
			expected_sums.push_back(32'd0);
		end else begin
			running_sum = round_real(single_to_real(running_sum)
				+ single_to_real(element_term(e)), 1'b0);
			if (e.last) begin
				s = running_sum;
				if (s[30:23] == 8'hFF && s[22:0] != 23'd0)
					s = vra_pkg::CANON_NAN;
				expected_sums.push_back(s);
				running_sum = 32'd0;
			end
		end
	endtask

	// ---------------- stimulus ----------------

	task automatic add_elem(input logic [1:0] req, input logic half, input logic [31:0] lhs,
			input logic [31:0] rhs, input logic last, input logic empty);
		vec_elem_t e;
		e.req   = req;
		e.half  = half;
		e.lhs   = lhs;
		e.rhs   = rhs;
		e.last  = last;
		e.empty = empty;
		pending_elems.push_back(e);
	endtask

	function automatic logic [31:0] rand_single();
		logic [31:0] specials[10];
		logic [31:0] r;
		specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
			32'h7FC0_0001, 32'hFFFF_FFFF, 32'h0000_0001, 32'h007F_FFFF,
			32'h7F7F_FFFF, 32'h3F80_0000};
		r = $urandom;
		case ($urandom_range(9))
			0, 1: ;
			7: r = specials[$urandom_range(9)];
			8: r[30:23] = 8'd0;
			9: r[30:23] = 8'(240 + $urandom_range(13));
			default: r[30:23] = 8'(115 + $urandom_range(24));
		endcase
		return r;
	endfunction

	// Upper half stays random, it must be ignored
	function automatic logic [31:0] rand_half();
		logic [15:0] specials[8];
		logic [31:0] r;
		specials = '{16'h0000, 16'h8000, 16'h7C00, 16'hFC00, 16'h7E01, 16'h0001,
			16'h03FF, 16'h7BFF};
		r = $urandom;
		case ($urandom_range(9))
			0, 1: ;
			7: r[15:0] = specials[$urandom_range(7)];
			8: r[14:10] = 5'd0;
			default: r[14:10] = 5'(10 + $urandom_range(10));
		endcase
		return r;
	endfunction

	task automatic add_random_vectors(input int count);
		int          n;
		int          len;
		logic [1:0]  req;
		logic        half;
		n = 0;
		while (n < count) begin
			len  = $urandom_range(7);
			req  = 2'($urandom_range(3));
			half = 1'($urandom);
			if (len == 0) begin
				add_elem(2'($urandom), 1'($urandom), $urandom, $urandom, 1'($urandom), 1'b1);
				n++;
			end else begin
				for (int i = 0; i < len; i++) begin
					// occasional broken vector: a stray empty word mid-stream
					if ($urandom_range(99) < 3) begin
						add_elem(2'($urandom), 1'($urandom), $urandom, $urandom,
							1'($urandom), 1'b1);
						n++;
					end
					if ($urandom_range(99) < 10) begin
						req  = 2'($urandom_range(3));
						half = 1'($urandom);
					end
					if (half)
						add_elem(req, half, rand_half(), rand_half(), i == len - 1, 1'b0);
					else
						add_elem(req, half, rand_single(), rand_single(), i == len - 1, 1'b0);
					n++;
				end
			end
		end
	endtask

	task automatic drain_all();
		wait (pending_elems.size() == 0 && !s_tvalid);
		wait (expected_sums.size() == 0);
		@(posedge clk);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, every operation, special cases
		send_idle_pct = 9;
		recv_idle_pct = 55;
		add_elem(vra_pkg::REQ_SUM, 1'b0, 32'h3F80_0000, 32'hFFFF_FFFF, 1'b1, 1'b0);
		add_elem(vra_pkg::REQ_DOT, 1'b0, 32'h4040_0000, 32'hC000_0000, 1'b0, 1'b0);
		add_elem(vra_pkg::REQ_DOT, 1'b0, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b1, 1'b0);
		add_elem(vra_pkg::REQ_SQD, 1'b0, 32'h4120_0000, 32'h3F80_0000, 1'b1, 1'b0);
		add_elem(vra_pkg::REQ_ALT, 1'b0, 32'h0000_0001, 32'h7FC0_0000, 1'b1, 1'b0);
		add_elem(vra_pkg::REQ_SUM, 1'b0, 32'h7F80_0000, 32'h0, 1'b0, 1'b0);
		add_elem(vra_pkg::REQ_SUM, 1'b0, 32'hFF80_0000, 32'h0, 1'b1, 1'b0);
		add_elem(vra_pkg::REQ_DOT, 1'b0, 32'hFFFF_FFFF, 32'h3F80_0000, 1'b1, 1'b0);
		add_elem(vra_pkg::REQ_DOT, 1'b0, 32'h0000_0001, 32'h0000_0001, 1'b1, 1'b0);
		add_elem(vra_pkg::REQ_SUM, 1'b0, 32'h8000_0000, 32'h0, 1'b0, 1'b0);
		add_elem(vra_pkg::REQ_DOT, 1'b0, 32'h8000_0000, 32'h3F80_0000, 1'b1, 1'b0);
		add_elem(vra_pkg::REQ_SUM, 1'b0, 32'h3F80_0000, 32'h0, 1'b0, 1'b0);
		add_elem(vra_pkg::REQ_SUM, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1);
		add_elem(vra_pkg::REQ_SUM, 1'b1, 32'hABCD_3C00, 32'h1234_0000, 1'b1, 1'b0);
		add_elem(vra_pkg::REQ_DOT, 1'b1, 32'hFFFF_7BFF, 32'hFFFF_7BFF, 1'b1, 1'b0);
		add_elem(vra_pkg::REQ_DOT, 1'b1, 32'h0000_0001, 32'h0000_3800, 1'b1, 1'b0);
		add_elem(vra_pkg::REQ_SQD, 1'b1, 32'h5555_7BFF, 32'hAAAA_FBFF, 1'b1, 1'b0);
		add_elem(vra_pkg::REQ_SQD, 1'b1, 32'h0000_7C00, 32'h0000_7C00, 1'b1, 1'b0);
		add_elem(vra_pkg::REQ_ALT, 1'b1, 32'h0000_7E01, 32'h0, 1'b1, 1'b0);
		add_elem(vra_pkg::REQ_DOT, 1'b1, 32'h0000_8000, 32'h0000_3C00, 1'b1, 1'b0);
		add_elem(vra_pkg::REQ_SQD, 1'b0, 32'h0000_0003, 32'h8000_0001, 1'b1, 1'b0);
		drain_all();

		add_random_vectors(330);
		drain_all();

		send_idle_pct = 55;
		recv_idle_pct = 9;
		add_random_vectors(330);
		drain_all();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		add_random_vectors(340);
		drain_all();

		repeat (20) @(posedge clk);
		if (!failed)
			$display("vector_reduce_accumulator_top test passed");
		else
			$display("vector_reduce_accumulator_top test failed");
		$finish;
	end

	// ---------------- driver ----------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 64'd0;
			s_tuser  <= 4'd0;
			s_tlast  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				fold_element(driven_elem);
			if (!s_tvalid || s_tready) begin
				if (pending_elems.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					driven_elem = pending_elems.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {driven_elem.rhs, driven_elem.lhs};
					s_tuser  <= {driven_elem.empty, driven_elem.half, driven_elem.req};
					s_tlast  <= driven_elem.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------- receiver and monitor ----------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
			if (m_tvalid && m_tready) begin
				if (expected_sums.size() == 0) begin
					$error("unexpected word: sum_value actual %h", m_tdata);
					failed = 1'b1;
				end else begin
					if (m_tdata !== expected_sums[0]) begin
						$error("sum_value mismatch: expected %h actual %h",
							expected_sums[0], m_tdata);
						failed = 1'b1;
					end
					void'(expected_sums.pop_front());
				end
			end
		end
	end

	// ---------------- watchdog ----------------
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("vector_reduce_accumulator_top test failed");
			$finish;
		end
	end

endmodule

// ===== filelist.f =====
rtl/vra_pkg.sv
rtl/vra_queue.sv
rtl/vra_front.sv
rtl/vra_back.sv
rtl/vector_reduce_accumulator_top.sv
tb/sv/vector_reduce_accumulator_top_test.sv
